// File: rtl/hmg_pkg.sv
package hmg_pkg;

    // Largest map the row buffers hold.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_LENGTH = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_LENGTH) + 1;
    localparam int CMP_W   = 14;
    localparam int CFG_W   = 11;
    localparam int SCALE_W = 12;
    localparam int DATA_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int HGT_W   = 20;
    localparam int IDX_W   = 20;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 32;
    localparam int NUM_W   = 20;
    localparam int CNT_W   = 5;
    localparam int SQV_W   = 62;
    localparam int SUM_W   = 42;
    localparam int NRM_W   = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAP_LENGTH   = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

    // Result kinds.
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // Offsets of a triangle corner from the vertex index.
    localparam logic [1:0] OFS_ZERO  = 2'd0;
    localparam logic [1:0] OFS_W     = 2'd1;
    localparam logic [1:0] OFS_W_ONE = 2'd2;
    localparam logic [1:0] OFS_ONE   = 2'd3;

    typedef struct packed {
        logic                start;
        logic [REM_W-1:0]    init_rem;
        logic [NUM_W-1:0]    num;
        logic [CNT_W-1:0]    steps;
        logic [ROOT_W-1:0]   divisor;
    } div_req_t;

    // Corner order of the two triangles of a quad; the diagonal flips with
    // the parity of the vertex index.
    function automatic logic [1:0] tri_offset(input logic [2:0] step, input logic odd);
        logic [1:0] code;
        code = OFS_ZERO;
        if (!odd) begin
            case (step)
                3'd0:    code = OFS_ZERO;
                3'd1:    code = OFS_W;
                3'd2:    code = OFS_W_ONE;
                3'd3:    code = OFS_ZERO;
                3'd4:    code = OFS_W_ONE;
                3'd5:    code = OFS_ONE;
                default: code = OFS_ZERO;
            endcase
        end
        else begin
            case (step)
                3'd0:    code = OFS_ZERO;
                3'd1:    code = OFS_W;
                3'd2:    code = OFS_ONE;
                3'd3:    code = OFS_ONE;
                3'd4:    code = OFS_W;
                3'd5:    code = OFS_W_ONE;
                default: code = OFS_ZERO;
            endcase
        end
        return code;
    endfunction

endpackage

// File: rtl/hmg_row_mem.sv
module hmg_row_mem
    import hmg_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic              wr_sel,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_sel,
    input  logic [COL_W-1:0]  rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    // Two row buffers; buffer A is select 0.
    logic [BYTE_W-1:0] buf_a [MAX_WIDTH];
    logic [BYTE_W-1:0] buf_b [MAX_WIDTH];
    logic [BYTE_W-1:0] rd_a_reg;
    logic [BYTE_W-1:0] rd_b_reg;
    logic              rd_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_sel)
        begin
            buf_a[wr_addr] <= wr_data;
        end
        rd_a_reg <= buf_a[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_sel)
        begin
            buf_b[wr_addr] <= wr_data;
        end
        rd_b_reg <= buf_b[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        rd_sel_reg <= rd_sel;
    end

    assign rd_data = rd_sel_reg ? rd_b_reg : rd_a_reg;

endmodule

// File: rtl/hmg_divider.sv
module hmg_divider
    import hmg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    // Restoring division, two quotient bits per cycle.
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [ROOT_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        logic [REM_W-1:0] t;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        for (int j = 0; j < 2; j++)
        begin
            t = {rem_next[REM_W-2:0], num_next[NUM_W-1]};
            num_next = {num_next[NUM_W-2:0], 1'b0};
            if (t >= REM_W'(div_reg))
            begin
                t = t - REM_W'(div_reg);
                quot_next = {quot_next[NUM_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_next[NUM_W-2:0], 1'b0};
            end
            rem_next = t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(2);
            if (cnt_reg <= CNT_W'(2))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.init_rem;
            num_reg  <= req.num;
            quot_reg <= '0;
            div_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/hmg_sqrt.sv
module hmg_sqrt
    import hmg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQV_W-1:0]  value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    // Digit-by-digit integer square root, two result bits per cycle.
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg;
    logic        done_reg;

    always_comb
    begin
        v_next   = v_reg;
        r_next   = r_reg;
        bit_next = bit_reg;
        for (int j = 0; j < 2; j++)
        begin
            if (v_next >= r_next + bit_next)
            begin
                v_next = v_next - (r_next + bit_next);
                r_next = (r_next >> 1) + bit_next;
            end
            else
            begin
                r_next = r_next >> 1;
            end
            bit_next = bit_next >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (bit_next == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= 64'(value);
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            bit_reg <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

// File: rtl/heightmap_mesh_generator.sv
// Streaming heightmap-to-mesh generator. Heightmap bytes enter in raster order;
// each transaction carries one pixel or a pad. The first row is only stored.
// From the second row on, each pixel produces the vertex record of the pixel
// above it, followed by six triangle indices unless that pixel sits in the last
// column; after the image, one pad (or pixel) per column drains the last row,
// and the end of that drain starts a new image. The block works on one
// transaction at a time: a stored or ignored transaction leaves it idle, while a
// transaction that yields results stalls the input until its last result has been
// loaded into the output register. The stall is set by the shared restoring
// divider (two bits a cycle, five height divisions of 20 bits and three normal
// divisions of 18 bits), the square-root unit, the row-buffer reads through a
// single read port and the emission of each result. Results leave through
// an output register, so the next transaction may be accepted while the last
// result still waits. Configuration is written with cfg_wr_en, cfg_index and
// cfg_data; the user must do so only while idle; the block does not enforce it.
// map_width and map_length are clamped to 1..1024; map_width divides heights.
module heightmap_mesh_generator
    import hmg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [DATA_W-1:0]       cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [BYTE_W-1:0]       height_byte,
    input  logic                    pad,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    kind,
    output logic signed [10:0]      pos_x,
    output logic [19:0]             pos_y,
    output logic signed [10:0]      pos_z,
    output logic [9:0]              tex_u,
    output logic [9:0]              tex_v,
    output logic signed [15:0]      norm_x,
    output logic [14:0]             norm_y,
    output logic signed [15:0]      norm_z,
    output logic [19:0]             index_value,
    output logic                    last
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RD0   = 5'd1;
    localparam logic [4:0] ST_RD1   = 5'd2;
    localparam logic [4:0] ST_RD2   = 5'd3;
    localparam logic [4:0] ST_RD3   = 5'd4;
    localparam logic [4:0] ST_RD4   = 5'd5;
    localparam logic [4:0] ST_HDIV  = 5'd6;
    localparam logic [4:0] ST_HWAIT = 5'd7;
    localparam logic [4:0] ST_DIFF  = 5'd8;
    localparam logic [4:0] ST_SQX   = 5'd9;
    localparam logic [4:0] ST_SQZ   = 5'd10;
    localparam logic [4:0] ST_SUM   = 5'd11;
    localparam logic [4:0] ST_ROOT  = 5'd12;
    localparam logic [4:0] ST_RWAIT = 5'd13;
    localparam logic [4:0] ST_NDIV  = 5'd14;
    localparam logic [4:0] ST_NWAIT = 5'd15;
    localparam logic [4:0] ST_EMIT  = 5'd16;

    // Configuration registers.
    logic [CFG_W-1:0]   map_width_reg;
    logic [CFG_W-1:0]   map_length_reg;
    logic [SCALE_W-1:0] height_scale_reg;

    // Stream position.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             sel_reg;
    logic [IDX_W-1:0] vidx_reg;

    // Per-transaction working registers.
    logic [4:0]        state_reg;
    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  z_reg;
    logic [IDX_W-1:0]  i_reg;
    logic              wsel_reg;
    logic              drain_reg;
    logic              tri_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] bcx_reg;
    logic [BYTE_W-1:0] bxl_reg;
    logic [BYTE_W-1:0] bxr_reg;
    logic [BYTE_W-1:0] bwx_reg;
    logic [2:0]        hk_reg;
    logic [HGT_W-1:0]  h_reg [5];
    logic signed [HGT_W:0] dx_reg;
    logic signed [HGT_W:0] dz_reg;
    logic [39:0]       sqx_reg;
    logic [39:0]       sqz_reg;
    logic [SUM_W-1:0]  s_reg;
    logic [1:0]        nk_reg;
    logic [NRM_W-1:0]  nrm_reg [3];
    logic [2:0]        ek_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   kind_reg;
    logic [10:0]            pos_x_reg;
    logic [19:0]            pos_y_reg;
    logic [10:0]            pos_z_reg;
    logic [9:0]             tex_u_reg;
    logic [9:0]             tex_v_reg;
    logic [15:0]            norm_x_reg;
    logic [14:0]            norm_y_reg;
    logic [15:0]            norm_z_reg;
    logic [19:0]            index_value_reg;
    logic                   last_reg;

    // Effective map dimensions, clamped to one and to the buffer size.
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] len_eff;

    always_comb
    begin
        if (map_width_reg == '0)
            w_eff = CMP_W'(1);
        else if (CMP_W'(map_width_reg) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(map_width_reg);
        if (map_length_reg == '0)
            len_eff = CMP_W'(1);
        else if (CMP_W'(map_length_reg) > CMP_W'(MAX_LENGTH))
            len_eff = CMP_W'(MAX_LENGTH);
        else
            len_eff = CMP_W'(map_length_reg);
    end

    // Accept decode. A pad before the drain is swallowed; a first-row pixel
    // is written straight into the buffer; everything else starts the
    // sequencer. Once the image rows are all in, any transaction drains.
    logic accept;
    logic draining;
    logic ignore_item;
    logic store_only;
    logic row_end;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign draining    = CMP_W'(row_reg) >= len_eff;
    assign ignore_item = !draining && pad;
    assign store_only  = !draining && !pad && (row_reg == '0);
    assign row_end     = (CMP_W'(col_reg) + CMP_W'(1)) >= w_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= CFG_W'(1024);
            map_length_reg   <= CFG_W'(1024);
            height_scale_reg <= SCALE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:    map_width_reg    <= cfg_data[CFG_W-1:0];
                REG_MAP_LENGTH:   map_length_reg   <= cfg_data[CFG_W-1:0];
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Column, row, buffer select and vertex index move on at accept time; the
    // sequencer works from its own copies.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            sel_reg  <= 1'b0;
            vidx_reg <= '0;
        end
        else if (accept && !ignore_item)
        begin
            if (!store_only)
            begin
                vidx_reg <= vidx_reg + IDX_W'(1);
            end
            if (row_end)
            begin
                col_reg <= '0;
                if (draining)
                begin
                    row_reg  <= '0;
                    sel_reg  <= 1'b0;
                    vidx_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                    sel_reg <= !sel_reg;
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Row buffers: the write buffer takes the current row, the other holds
    // the row above.
    logic              mem_wr_en;
    logic              mem_wr_sel;
    logic [COL_W-1:0]  mem_wr_addr;
    logic [BYTE_W-1:0] mem_wr_data;
    logic              mem_rd_sel;
    logic [COL_W-1:0]  mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;
    logic [COL_W-1:0]  x_left;
    logic [COL_W-1:0]  x_right;

    assign x_left  = (x_reg == '0) ? x_reg : x_reg - COL_W'(1);
    assign x_right = ((CMP_W'(x_reg) + CMP_W'(1)) < w_eff) ? x_reg + COL_W'(1) : x_reg;

    always_comb
    begin
        mem_wr_en   = accept && store_only;
        mem_wr_sel  = sel_reg;
        mem_wr_addr = col_reg;
        mem_wr_data = height_byte;
        if (state_reg == ST_RD4 && !drain_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_sel  = wsel_reg;
            mem_wr_addr = x_reg;
            mem_wr_data = byte_reg;
        end
        mem_rd_sel  = !wsel_reg;
        mem_rd_addr = x_reg;
        case (state_reg)
            ST_RD1:  mem_rd_addr = x_left;
            ST_RD2:  mem_rd_addr = x_right;
            ST_RD3:  mem_rd_sel  = wsel_reg;
            default: mem_rd_addr = x_reg;
        endcase
    end

    hmg_row_mem u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_sel  (mem_wr_sel),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_sel  (mem_rd_sel),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Shared divider: heights first (byte times scale over width), then the
    // three normal components (magnitude scaled by 2^25 over the root, rounded).
    div_req_t          div_req;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [BYTE_W-1:0] h_byte;
    logic [NUM_W-1:0]  h_prod;
    logic signed [HGT_W:0] comp;
    logic [HGT_W-1:0]  comp_mag;
    logic [45:0]       norm_num;
    logic              sqrt_start;
    logic [ROOT_W-1:0] root;
    logic              sqrt_done;

    always_comb
    begin
        case (hk_reg)
            3'd0:    h_byte = bcx_reg;
            3'd1:    h_byte = bxl_reg;
            3'd2:    h_byte = bxr_reg;
            3'd3:    h_byte = (z_reg == '0) ? bcx_reg : bwx_reg;
            default: h_byte = drain_reg ? bcx_reg : byte_reg;
        endcase
        h_prod = NUM_W'(h_byte) * NUM_W'(height_scale_reg);

        case (nk_reg)
            2'd0:    comp = dx_reg;
            2'd1:    comp = (HGT_W+1)'(2);
            default: comp = dz_reg;
        endcase
        comp_mag = comp[HGT_W] ? HGT_W'(-comp) : HGT_W'(comp);
        norm_num = {1'b0, comp_mag, 25'd0} + 46'(root >> 1);

        div_req = '0;
        if (state_reg == ST_HDIV)
        begin
            div_req.start    = 1'b1;
            div_req.init_rem = '0;
            div_req.num      = h_prod;
            div_req.steps    = CNT_W'(20);
            div_req.divisor  = ROOT_W'(w_eff);
        end
        else if (state_reg == ST_NDIV)
        begin
            div_req.start    = 1'b1;
            div_req.init_rem = REM_W'(norm_num[45:18]);
            div_req.num      = {norm_num[17:0], 2'b00};
            div_req.steps    = CNT_W'(18);
            div_req.divisor  = root;
        end
    end

    hmg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign sqrt_start = (state_reg == ST_ROOT);

    hmg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value ({s_reg[SUM_W-1:0], 20'd0}),
        .done  (sqrt_done),
        .root  (root)
    );

    // Saturate a normal quotient to Q1.15 with the sign of its component.
    logic [NRM_W-1:0] norm_sat;
    logic [17:0]      q18;

    always_comb
    begin
        q18 = div_quot[17:0];
        if (!comp[HGT_W])
        begin
            norm_sat = (q18 > 18'd32767) ? NRM_W'(32767) : NRM_W'(q18);
        end
        else
        begin
            norm_sat = (q18 > 18'd32768) ? NRM_W'(-32768) : NRM_W'(-q18);
        end
    end

    // Result generation into the output register.
    logic             out_load;
    logic             emit_last;
    logic [1:0]       ofs_code;
    logic [IDX_W-1:0] tri_index;
    logic [2:0]       tri_step;

    assign out_load  = !out_valid_reg || !out_stall;
    assign emit_last = (ek_reg == 3'd0) ? !tri_reg : (ek_reg == 3'd6);
    assign tri_step  = ek_reg - 3'd1;
    assign ofs_code  = tri_offset(tri_step, i_reg[0]);

    always_comb
    begin
        case (ofs_code)
            OFS_W:     tri_index = i_reg + IDX_W'(w_eff);
            OFS_W_ONE: tri_index = i_reg + IDX_W'(w_eff) + IDX_W'(1);
            OFS_ONE:   tri_index = i_reg + IDX_W'(1);
            default:   tri_index = i_reg;
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hk_reg    <= '0;
            nk_reg    <= '0;
            ek_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !ignore_item && !store_only)
                        state_reg <= ST_RD0;
                end
                ST_RD0:  state_reg <= ST_RD1;
                ST_RD1:  state_reg <= ST_RD2;
                ST_RD2:  state_reg <= ST_RD3;
                ST_RD3:  state_reg <= ST_RD4;
                ST_RD4:
                begin
                    hk_reg    <= '0;
                    state_reg <= ST_HDIV;
                end
                ST_HDIV: state_reg <= ST_HWAIT;
                ST_HWAIT:
                begin
                    if (div_done)
                    begin
                        if (hk_reg == 3'd4)
                            state_reg <= ST_DIFF;
                        else
                        begin
                            hk_reg    <= hk_reg + 3'd1;
                            state_reg <= ST_HDIV;
                        end
                    end
                end
                ST_DIFF:  state_reg <= ST_SQX;
                ST_SQX:   state_reg <= ST_SQZ;
                ST_SQZ:   state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_ROOT;
                ST_ROOT:  state_reg <= ST_RWAIT;
                ST_RWAIT:
                begin
                    if (sqrt_done)
                    begin
                        nk_reg    <= '0;
                        state_reg <= ST_NDIV;
                    end
                end
                ST_NDIV: state_reg <= ST_NWAIT;
                ST_NWAIT:
                begin
                    if (div_done)
                    begin
                        if (nk_reg == 2'd2)
                        begin
                            ek_reg    <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            nk_reg    <= nk_reg + 2'd1;
                            state_reg <= ST_NDIV;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        ek_reg <= ek_reg + 3'd1;
                        if (emit_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Working data path registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= col_reg;
            z_reg     <= row_reg - ROW_W'(1);
            i_reg     <= vidx_reg;
            wsel_reg  <= sel_reg;
            drain_reg <= draining;
            tri_reg   <= !draining && !row_end;
            byte_reg  <= height_byte;
        end
        case (state_reg)
            ST_RD1: bcx_reg <= mem_rd_data;
            ST_RD2: bxl_reg <= mem_rd_data;
            ST_RD3: bxr_reg <= mem_rd_data;
            ST_RD4: bwx_reg <= mem_rd_data;
            ST_HWAIT:
            begin
                if (div_done)
                    h_reg[hk_reg] <= div_quot;
            end
            ST_DIFF:
            begin
                dx_reg <= $signed({1'b0, h_reg[1]}) - $signed({1'b0, h_reg[2]});
                dz_reg <= $signed({1'b0, h_reg[3]}) - $signed({1'b0, h_reg[4]});
            end
            ST_SQX: sqx_reg <= 40'(dx_reg) * 40'(dx_reg);
            ST_SQZ: sqz_reg <= 40'(dz_reg) * 40'(dz_reg);
            ST_SUM: s_reg   <= SUM_W'(sqx_reg) + SUM_W'(sqz_reg) + SUM_W'(4);
            ST_NWAIT:
            begin
                if (div_done)
                    nrm_reg[nk_reg] <= norm_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= (state_reg == ST_EMIT);
    end

    // The first result is the vertex record; triangle indices carry zeros in
    // every vertex field.
    always_ff @(posedge clk)
    begin
        if (out_load && state_reg == ST_EMIT)
        begin
            last_reg <= emit_last;
            if (ek_reg == 3'd0)
            begin
                kind_reg        <= KIND_VERTEX;
                pos_x_reg       <= 11'(x_reg) - 11'(w_eff >> 1);
                pos_y_reg       <= h_reg[0];
                pos_z_reg       <= 11'(z_reg) - 11'(len_eff >> 1);
                tex_u_reg       <= 10'(x_reg);
                tex_v_reg       <= 10'(z_reg);
                norm_x_reg      <= nrm_reg[0];
                norm_y_reg      <= nrm_reg[1][14:0];
                norm_z_reg      <= nrm_reg[2];
                index_value_reg <= i_reg;
            end
            else
            begin
                kind_reg        <= KIND_INDEX;
                pos_x_reg       <= '0;
                pos_y_reg       <= '0;
                pos_z_reg       <= '0;
                tex_u_reg       <= '0;
                tex_v_reg       <= '0;
                norm_x_reg      <= '0;
                norm_y_reg      <= '0;
                norm_z_reg      <= '0;
                index_value_reg <= tri_index;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign norm_x      = norm_x_reg;
    assign norm_y      = norm_y_reg;
    assign norm_z      = norm_z_reg;
    assign index_value = index_value_reg;
    assign last        = last_reg;

endmodule

// File: verif/heightmap_mesh_generator_tb.sv
module heightmap_mesh_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmg_pkg::*;

    // One result of the block, held at the block's own widths.
    typedef struct {
        logic        kind;
        logic [10:0] pos_x;
        logic [19:0] pos_y;
        logic [10:0] pos_z;
        logic [9:0]  tex_u;
        logic [9:0]  tex_v;
        logic [15:0] norm_x;
        logic [14:0] norm_y;
        logic [15:0] norm_z;
        logic [19:0] index_value;
        logic        last;
    } mesh_result_t;

    // The scoreboard keeps its own copy of the row buffers, the raster position and the
    // configuration, and turns each accepted transaction into the results it must cause.
    class mesh_scoreboard;
        logic [7:0]   rows_a [MAX_WIDTH];
        logic [7:0]   rows_b [MAX_WIDTH];
        logic         fill_b;
        int unsigned  col;
        int unsigned  row;
        logic [19:0]  vert_idx;
        int unsigned  width_reg;
        int unsigned  length_reg;
        int unsigned  scale_reg;
        mesh_result_t expected_results[$];
        int           errors;
        int           checked;
        int           vertices;

        function new();
            foreach (rows_a[k]) begin
                rows_a[k] = '0;
                rows_b[k] = '0;
            end
            fill_b = 1'b0;
            col = 0;
            row = 0;
            vert_idx = '0;
            width_reg = 1024;
            length_reg = 1024;
            scale_reg = 1;
            errors = 0;
            checked = 0;
            vertices = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [DATA_W-1:0] data);
            if (idx == REG_MAP_WIDTH)
                width_reg = data[10:0];
            else if (idx == REG_MAP_LENGTH)
                length_reg = data[10:0];
            else if (idx == REG_HEIGHT_SCALE)
                scale_reg = data[11:0];
        endfunction

        function longint height_of(logic [7:0] b, int unsigned w);
            return (longint'(b) * longint'(scale_reg)) / longint'(w);
        endfunction

        // Bitwise integer square root, two bits of the radicand per step.
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned bit_pos;
            r = 0;
            bit_pos = 64'd1 << 62;
            while (bit_pos > v)
                bit_pos = bit_pos >> 2;
            while (bit_pos != 0) begin
                if (v >= r + bit_pos) begin
                    v = v - (r + bit_pos);
                    r = (r >> 1) + bit_pos;
                end
                else
                    r = r >> 1;
                bit_pos = bit_pos >> 2;
            end
            return r;
        endfunction

        // One normal component in Q1.15: rounded quotient, saturated at plus or minus one.
        function logic [15:0] normal_part(longint c, longint unsigned r);
            longint unsigned mag;
            longint unsigned q;
            mag = (c < 0) ? longint'(-c) : longint'(c);
            q = ((mag << 25) + r / 2) / r;
            if (c >= 0)
                return (q > 32767) ? 16'd32767 : q[15:0];
            if (q > 32768)
                q = 32768;
            return 16'(0 - q);
        endfunction

        function void queue_result(mesh_result_t t);
            expected_results = {expected_results, t};
        endfunction

        function void push_corner(logic [19:0] v);
            mesh_result_t t;
            t = '{default: '0};
            t.kind = KIND_INDEX;
            t.index_value = v;
            queue_result(t);
        endfunction

        function void note_transaction(logic [7:0] b, logic is_pad);
            int unsigned  w;
            int unsigned  len;
            int unsigned  z;
            int unsigned  xl;
            int unsigned  xr;
            int unsigned  x;
            logic         draining;
            logic [7:0]   above;
            logic [7:0]   below;
            logic [7:0]   mid;
            logic [7:0]   lft;
            logic [7:0]   rgt;
            longint       dx;
            longint       dz;
            longint unsigned r;
            mesh_result_t v;
            logic [19:0]  i;
            w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            len = (length_reg < 1) ? 1 : ((length_reg > MAX_LENGTH) ? MAX_LENGTH : length_reg);
            draining = (row >= len);
            x = col;
            if (!draining && is_pad)
                return;
            if (!draining && row == 0) begin
                if (fill_b) rows_b[x] = b; else rows_a[x] = b;
            end
            else begin
                // The buffer being filled still holds the row above the vertex and then takes the row
                // below it; the other one holds the vertex's own row. In the first emitted row the row
                // above clamps to the vertex itself.
                z = row - 1;
                xl = (x != 0) ? x - 1 : 0;
                xr = (x + 1 < w) ? x + 1 : x;
                mid = fill_b ? rows_a[x] : rows_b[x];
                lft = fill_b ? rows_a[xl] : rows_b[xl];
                rgt = fill_b ? rows_a[xr] : rows_b[xr];
                above = (z == 0) ? mid : (fill_b ? rows_b[x] : rows_a[x]);
                below = draining ? mid : b;
                dx = height_of(lft, w) - height_of(rgt, w);
                dz = height_of(above, w) - height_of(below, w);
                r = int_sqrt((unsigned'(dx * dx + dz * dz + 4)) << 20);
                i = vert_idx;
                if (!draining) begin
                    if (fill_b) rows_b[x] = b; else rows_a[x] = b;
                end
                v.kind = KIND_VERTEX;
                v.pos_x = 11'(longint'(x) - longint'(w / 2));
                v.pos_y = 20'(height_of(mid, w));
                v.pos_z = 11'(longint'(z) - longint'(len / 2));
                v.tex_u = x[9:0];
                v.tex_v = z[9:0];
                v.norm_x = normal_part(dx, r);
                v.norm_y = 15'(normal_part(2, r));
                v.norm_z = normal_part(dz, r);
                v.index_value = i;
                v.last = 1'b0;
                queue_result(v);
                vertices++;
                if (!draining && x + 1 < w) begin
                    push_corner(i);
                    push_corner(i + 20'(w));
                    if (!i[0]) begin
                        push_corner(i + 20'(w) + 20'd1);
                        push_corner(i);
                        push_corner(i + 20'(w) + 20'd1);
                        push_corner(i + 20'd1);
                    end
                    else begin
                        push_corner(i + 20'd1);
                        push_corner(i + 20'd1);
                        push_corner(i + 20'(w));
                        push_corner(i + 20'(w) + 20'd1);
                    end
                end
                expected_results[$].last = 1'b1;
                vert_idx = vert_idx + 20'd1;
            end
            if (x + 1 >= w) begin
                col = 0;
                if (draining) begin
                    row = 0;
                    fill_b = 1'b0;
                    vert_idx = '0;
                end
                else begin
                    row++;
                    fill_b = ~fill_b;
                end
            end
            else
                col++;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] error: %s", $realtime, what);
        endtask

        task check_result(mesh_result_t got);
            mesh_result_t e;
            checked++;
            if (expected_results.size() == 0) begin
                report("result arrived with nothing outstanding");
                return;
            end
            e = expected_results.pop_front();
            if (got.kind !== e.kind) report($sformatf("kind %0d, want %0d", got.kind, e.kind));
            if (got.pos_x !== e.pos_x) report($sformatf("pos_x %h, want %h", got.pos_x, e.pos_x));
            if (got.pos_y !== e.pos_y) report($sformatf("pos_y %h, want %h", got.pos_y, e.pos_y));
            if (got.pos_z !== e.pos_z) report($sformatf("pos_z %h, want %h", got.pos_z, e.pos_z));
            if (got.tex_u !== e.tex_u) report($sformatf("tex_u %h, want %h", got.tex_u, e.tex_u));
            if (got.tex_v !== e.tex_v) report($sformatf("tex_v %h, want %h", got.tex_v, e.tex_v));
            if (got.norm_x !== e.norm_x)
                report($sformatf("norm_x %h, want %h", got.norm_x, e.norm_x));
            if (got.norm_y !== e.norm_y)
                report($sformatf("norm_y %h, want %h", got.norm_y, e.norm_y));
            if (got.norm_z !== e.norm_z)
                report($sformatf("norm_z %h, want %h", got.norm_z, e.norm_z));
            if (got.index_value !== e.index_value)
                report($sformatf("index_value %h, want %h", got.index_value, e.index_value));
            if (got.last !== e.last) report($sformatf("last %0d, want %0d", got.last, e.last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] height_byte;
    logic              pad;
    logic              out_valid;
    logic              out_stall;
    logic              kind;
    logic signed [10:0] pos_x;
    logic [19:0]       pos_y;
    logic signed [10:0] pos_z;
    logic [9:0]        tex_u;
    logic [9:0]        tex_v;
    logic signed [15:0] norm_x;
    logic [14:0]       norm_y;
    logic signed [15:0] norm_z;
    logic [19:0]       index_value;
    logic              last;

    mesh_scoreboard mesh_sb;
    int  burst_left;
    int  pixels_sent;
    int  images_done;
    int  random_items;
    bit  long_hold_req;

    heightmap_mesh_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .height_byte (height_byte),
        .pad         (pad),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .index_value (index_value),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling: each result-bearing transaction stalls the input, a couple of
    // hundred transactions are sent, and the output may stall for long stretches.
    initial
    begin
        #40ms;
        $display("heightmap_mesh_generator: mismatch");
        $finish;
    end

    // Every accepted result is checked against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        mesh_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.kind = kind;
            got.pos_x = pos_x;
            got.pos_y = pos_y;
            got.pos_z = pos_z;
            got.tex_u = tex_u;
            got.tex_v = tex_v;
            got.norm_x = norm_x;
            got.norm_y = norm_y;
            got.norm_z = norm_z;
            got.index_value = index_value;
            got.last = last;
            mesh_sb.check_result(got);
        end
    end

    // The receiver stalls in stretches: no stall, light stall or heavy stall. On request it
    // holds off for a long counted stretch so the block backs up and stalls its input.
    initial
    begin
        int stretch;
        int pct;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_hold_req) begin
                out_stall = 1'b1;
                repeat (3000) @(negedge clk);
                long_hold_req = 1'b0;
            end
            stretch = $urandom_range(100, 10);
            case ($urandom_range(2, 0))
                0: pct = 0;
                1: pct = 25;
                default: pct = 80;
            endcase
            repeat (stretch) begin
                @(negedge clk);
                out_stall = ($urandom_range(99, 0) < pct);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transaction is taken.
    // The sender works in bursts with random gaps, and some bursts run very long.
    task automatic send_transaction(input logic [7:0] b, input logic is_pad);
        in_valid = 1'b1;
        height_byte = b;
        pad = is_pad;
        do
            @(posedge clk);
        while (in_stall);
        mesh_sb.note_transaction(b, is_pad);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else begin
            in_valid = 1'b0;
            height_byte = 8'($urandom);
            pad = 1'($urandom);
            repeat ($urandom_range(6, 1)) @(negedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? 60 : $urandom_range(8, 0);
        end
    endtask

    // Drops valid and waits until every expected result has come, then lets the block
    // finish any transaction that leaves no result behind.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (mesh_sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int unsigned value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value[DATA_W-1:0];
        @(posedge clk);
        mesh_sb.write_register(idx, value[DATA_W-1:0]);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(bit extremes);
        if (extremes || $urandom_range(7, 0) == 0)
            return $urandom_range(1, 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // One whole image and its drain. With noise, stray pads fall inside the image (the
    // block ignores them) and stray pixels fall inside the drain (treated as pads).
    task automatic run_image(input int unsigned w, input int unsigned len,
                             input int unsigned scale, input int noise_pct, input bit extremes);
        int unsigned wc;
        int unsigned lc;
        wc = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        lc = (len < 1) ? 1 : ((len > MAX_LENGTH) ? MAX_LENGTH : len);
        write_register(REG_MAP_WIDTH, w);
        write_register(REG_MAP_LENGTH, len);
        write_register(REG_HEIGHT_SCALE, scale);
        for (int p = 0; p < wc * lc; p++) begin
            if ($urandom_range(99, 0) < noise_pct)
                send_transaction(8'($urandom), 1'b1);
            send_transaction(pick_byte(extremes), 1'b0);
            pixels_sent++;
        end
        for (int c = 0; c < wc; c++)
            send_transaction(8'($urandom), ($urandom_range(99, 0) < noise_pct) ? 1'b0 : 1'b1);
        images_done++;
        wait_drained();
    endtask

    initial
    begin
        mesh_sb = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MAP_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        height_byte = '0;
        pad = 1'b0;
        burst_left = 0;
        pixels_sent = 0;
        images_done = 0;
        random_items = 0;
        long_hold_req = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a 3x3 map of extreme bytes (0x00 or 0xFF) with stray pads and drain pixels,
        // then width and length written as zero (both clamp to one) with the largest scale.
        run_image(3, 3, 4095, 30, 1'b1);
        run_image(0, 0, 4095, 0, 1'b1);

        // Width lowered in the middle of a row: the row ends at the next transaction and
        // the rest of the image continues at the narrower width.
        write_register(REG_MAP_WIDTH, 5);
        write_register(REG_MAP_LENGTH, 3);
        write_register(REG_HEIGHT_SCALE, 100);
        repeat (7) send_transaction(pick_byte(1'b0), 1'b0);
        wait_drained();
        write_register(REG_MAP_WIDTH, 2);
        repeat (3) send_transaction(pick_byte(1'b0), 1'b0);
        repeat (2) send_transaction(8'($urandom), 1'b1);
        images_done++;
        wait_drained();

        // A long receiver hold-off while the sender keeps offering pixels, so the block
        // backs up and stalls its input.
        long_hold_req = 1'b1;
        run_image(4, 3, 200, 0, 1'b0);

        // Random small maps.
        while (random_items < 115) begin
            int unsigned w;
            int unsigned len;
            int unsigned scale;
            w = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(9, 1);
            len = $urandom_range(4, 0);
            case ($urandom_range(3, 0))
                0: scale = 0;
                1: scale = 4095;
                default: scale = $urandom_range(4095, 0);
            endcase
            run_image(w, len, scale, 10, 1'b0);
            random_items += ((w < 1) ? 1 : w) * (((len < 1) ? 1 : len) + 1);
        end

        wait_drained();
        $display("covered %0d images, %0d pixels, %0d vertex records, %0d results checked",
                 images_done, pixels_sent, mesh_sb.vertices, mesh_sb.checked);
        $display("zero sizes clamped to one, width cut mid-row, scales 0 to 4095, long hold-off");
        if (mesh_sb.errors == 0 && mesh_sb.expected_results.size() == 0)
            $display("heightmap_mesh_generator: match");
        else
            $display("heightmap_mesh_generator: mismatch");
        $finish;
    end

endmodule
